@@ hw/rtl/shp_pkg.sv @@
// Package for the segment header parser: field widths, segment type codes,
// parser phase encoding and the result record type.
// No dependencies.
package shp_pkg;

    localparam int MAX_SDNV_BYTES = 9;
    localparam int SDNV_CNT_W     = 4;
    localparam int VALUE_W        = 63;
    localparam int RESULT_W       = 80;

    localparam logic [SDNV_CNT_W-1:0] SDNV_CNT_MAX  = SDNV_CNT_W'(MAX_SDNV_BYTES);
    localparam logic [SDNV_CNT_W-1:0] SDNV_CNT_SAT  = SDNV_CNT_W'(MAX_SDNV_BYTES + 1);
    localparam logic [VALUE_W-1:0]    VALUE_ALL_ONE = {VALUE_W{1'b1}};

    // Segment type codes (upper nibble of the header byte)
    localparam logic [3:0] TYPE_DATA      = 4'd1;
    localparam logic [3:0] TYPE_ACK       = 4'd2;
    localparam logic [3:0] TYPE_REFUSE    = 4'd3;
    localparam logic [3:0] TYPE_KEEPALIVE = 4'd4;
    localparam logic [3:0] TYPE_SHUTDOWN  = 4'd5;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_REASON = 3'b010,
        PH_SDNV   = 3'b100
    } phase_t;

    // First member lands in the top bits: seg_type ends up in the lowest bits
    typedef struct packed {
        logic               overflow;
        logic [VALUE_W-1:0] field_value;
        logic [7:0]         shut_reason;
        logic [3:0]         seg_flags;
        logic [3:0]         seg_type;
    } result_t;

endpackage

@@ hw/rtl/shp_in_reg.sv @@
// Input register of the segment header parser: holds one accepted byte
// until the parse stage consumes it. Depends on shp_pkg (import only).
module shp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       consume,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    import shp_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;

    // Take a new byte when empty or when the held one moves on this cycle
    assign s_tready   = !valid_reg || consume;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Load payload on each transaction
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

endmodule

@@ hw/rtl/shp_core.sv @@
// Parse stage of the segment header parser: header decode, reason capture
// and SDNV accumulation, one byte per cycle while step is high. Depends on shp_pkg.
module shp_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      byte_data,
    output logic            emit,
    output shp_pkg::result_t result
);
    import shp_pkg::*;

    phase_t                phase_reg,    phase_next;
    logic [3:0]            type_reg,     type_next;
    logic [3:0]            flags_reg,    flags_next;
    logic [7:0]            reason_reg,   reason_next;
    logic [VALUE_W-1:0]    acc_reg,      acc_next;
    logic [SDNV_CNT_W-1:0] cnt_reg,      cnt_next;
    logic                  ovf_reg,      ovf_next;

    logic [VALUE_W-1:0]    sdnv_acc;
    logic [SDNV_CNT_W-1:0] sdnv_cnt;
    logic                  sdnv_ovf;
    logic [3:0]            hdr_type;

    assign hdr_type = byte_data[7:4];

    // Shift in seven value bits, or saturate once the byte budget is spent
    always_comb begin
        if (cnt_reg < SDNV_CNT_MAX) begin
            sdnv_acc = {acc_reg[VALUE_W-8:0], byte_data[6:0]};
            sdnv_cnt = cnt_reg + SDNV_CNT_W'(1);
            sdnv_ovf = ovf_reg;
        end else begin
            sdnv_acc = VALUE_ALL_ONE;
            sdnv_cnt = SDNV_CNT_SAT;
            sdnv_ovf = 1'b1;
        end
    end

    // Next state and result record
    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        flags_next  = flags_reg;
        reason_next = reason_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        emit        = 1'b0;
        result      = '0;
        case (phase_reg)
            PH_REASON: begin
                reason_next = byte_data;
                phase_next  = PH_SDNV;
            end
            PH_SDNV: begin
                if (byte_data[7]) begin
                    acc_next = sdnv_acc;
                    cnt_next = sdnv_cnt;
                    ovf_next = sdnv_ovf;
                end else begin
                    emit               = 1'b1;
                    result.seg_type    = type_reg;
                    result.seg_flags   = flags_reg;
                    result.shut_reason = (type_reg == TYPE_SHUTDOWN) ? reason_reg : 8'd0;
                    result.field_value = sdnv_acc;
                    result.overflow    = sdnv_ovf;
                    phase_next  = PH_HEADER;
                    type_next   = '0;
                    flags_next  = '0;
                    reason_next = '0;
                    acc_next    = '0;
                    cnt_next    = '0;
                    ovf_next    = 1'b0;
                end
            end
            default: begin
                // Header byte: start a fresh segment
                reason_next = '0;
                acc_next    = '0;
                cnt_next    = '0;
                ovf_next    = 1'b0;
                type_next   = hdr_type;
                flags_next  = byte_data[3:0];
                if (hdr_type == TYPE_DATA || hdr_type == TYPE_ACK) begin
                    phase_next = PH_SDNV;
                end else if (hdr_type == TYPE_SHUTDOWN) begin
                    phase_next = PH_REASON;
                end else begin
                    // Refuse, keepalive and unknown types end at the header
                    emit             = 1'b1;
                    result.seg_type  = hdr_type;
                    result.seg_flags = byte_data[3:0];
                    phase_next = PH_HEADER;
                    type_next  = '0;
                    flags_next = '0;
                end
            end
        endcase
    end

    // Advance the parse state on each consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            type_reg   <= '0;
            flags_reg  <= '0;
            reason_reg <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            flags_reg  <= flags_next;
            reason_reg <= reason_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

@@ hw/rtl/shp_out_reg.sv @@
// Result register of the segment header parser: holds one finished record
// until the downstream side takes it. Depends on shp_pkg.
module shp_out_reg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  shp_pkg::result_t          result,
    output logic                      can_load,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [shp_pkg::RESULT_W-1:0] m_tdata
);
    import shp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Free when empty or when the held record leaves this cycle
    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    // Hold the record until its transaction completes
    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            data_reg <= result;
        end
    end

endmodule

@@ hw/rtl/segment_header_parser_top.sv @@
// Segment header parser for a delay-tolerant convergence-layer byte stream.
// Takes one byte per transaction and returns one record per finished
// header; a byte passes input register, parse stage and result register
// before its record appears. One byte is taken every cycle while the result
// side keeps up; the result register frees in the same cycle its record is
// taken, so ready chains back from m_tready through the parse stage to
// s_tready.
// Depends on shp_pkg, shp_in_reg, shp_core and shp_out_reg.
module segment_header_parser_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] in_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [3:0] seg_type, [7:4] seg_flags, [15:8] shut_reason,
    // [78:16] field_value, [79] overflow
    output logic [shp_pkg::RESULT_W-1:0] m_tdata
);
    import shp_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_free;
    logic       step;
    logic       emit;
    result_t    result;

    // Consume the held byte when the result register can take its record
    assign step = byte_valid && out_free;

    shp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    shp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_data (byte_data),
        .emit      (emit),
        .result    (result)
    );

    shp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && emit),
        .result   (result),
        .can_load (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/sv/segment_header_parser_top_tb.sv @@
// Self-checking testbench for segment_header_parser_top: a directed table and then
// random segment streams are pushed through the byte channel and each record is checked.
// Depends on shp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module segment_header_parser_top_tb;
    import shp_pkg::*;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;   // [7:0] in_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [3:0] seg_type, [7:4] seg_flags, [15:8] shut_reason,
    // [78:16] field_value, [79] overflow
    logic [RESULT_W-1:0] m_tdata;

    // Parser state as the testbench sees it
    phase_t               hdr_phase;
    logic [3:0]           hdr_type;
    logic [3:0]           hdr_flags;
    logic [7:0]           hdr_reason;
    logic [VALUE_W-1:0]   sdnv_acc;
    logic [SDNV_CNT_W-1:0] sdnv_count;
    logic                 sdnv_ovf;

    result_t    header_recs_due[$];
    int         err_count;
    bit         quiet;

    // Directed table
    logic [7:0] table_bytes[$];
    bit         table_typed[$];
    result_t    table_recs[$];

    segment_header_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic result_t mk_rec(input logic [3:0] seg_type, input logic [3:0] flags,
                                       input logic [7:0] reason,
                                       input logic [VALUE_W-1:0] value, input logic ovf);
        result_t rec;
        rec             = '0;
        rec.seg_type    = seg_type;
        rec.seg_flags   = flags;
        rec.shut_reason = reason;
        rec.field_value = value;
        rec.overflow    = ovf;
        return rec;
    endfunction

    function automatic void clear_segment();
        hdr_phase  = PH_HEADER;
        hdr_type   = '0;
        hdr_flags  = '0;
        hdr_reason = '0;
        sdnv_acc   = '0;
        sdnv_count = '0;
        sdnv_ovf   = 1'b0;
    endfunction

    // Advance the parser by one byte; returns 1 when a header record completes
    function automatic bit parse_byte(input logic [7:0] b, output result_t rec);
        rec = '0;
        case (hdr_phase)
            PH_REASON: begin
                hdr_reason = b;
                hdr_phase  = PH_SDNV;
                return 1'b0;
            end
            PH_SDNV: begin
                if (sdnv_count < SDNV_CNT_MAX) begin
                    sdnv_acc   = {sdnv_acc[VALUE_W-8:0], b[6:0]};
                    sdnv_count = sdnv_count + SDNV_CNT_W'(1);
                end else begin
                    // saturate once the length field runs too long
                    sdnv_ovf   = 1'b1;
                    sdnv_acc   = VALUE_ALL_ONE;
                    sdnv_count = SDNV_CNT_SAT;
                end
                if (b[7])
                    return 1'b0;
                rec = mk_rec(hdr_type, hdr_flags,
                             (hdr_type == TYPE_SHUTDOWN) ? hdr_reason : 8'h00,
                             sdnv_acc, sdnv_ovf);
                clear_segment();
                return 1'b1;
            end
            default: begin
                clear_segment();
                hdr_type  = b[7:4];
                hdr_flags = b[3:0];
                if (hdr_type == TYPE_DATA || hdr_type == TYPE_ACK) begin
                    hdr_phase = PH_SDNV;
                    return 1'b0;
                end
                if (hdr_type == TYPE_SHUTDOWN) begin
                    hdr_phase = PH_REASON;
                    return 1'b0;
                end
                // refuse, keepalive and unknown types end at the header byte
                rec = mk_rec(hdr_type, hdr_flags, 8'h00, '0, 1'b0);
                clear_segment();
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < 40)
            $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input result_t rec);
        table_bytes.push_back(b);
        table_typed.push_back(typed);
        table_recs.push_back(rec);
    endtask

    // Offer one byte, hold it until taken, then update the expected records
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_rec);
        result_t rec;
        bit      done;
        if (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        done = parse_byte(b, rec);
        if (typed)
            header_recs_due.push_back(typed_rec);
        else if (done)
            header_recs_due.push_back(rec);
    endtask

    // Length field of len bytes, continuation bit on all but the last
    task automatic send_sdnv(input int len);
        for (int i = 0; i < len; i++)
            send_byte({(i != len - 1), 7'($urandom_range(127))}, 1'b0, '0);
    endtask

    // Check records as they leave the block, and stall the result side
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (header_recs_due.size() == 0) begin
                report_mismatch($sformatf("record %h with none due", got));
            end else begin
                want = header_recs_due.pop_front();
                if (got.seg_type !== want.seg_type)
                    report_mismatch($sformatf("seg_type %h, want %h",
                                              got.seg_type, want.seg_type));
                if (got.seg_flags !== want.seg_flags)
                    report_mismatch($sformatf("seg_flags %h, want %h",
                                              got.seg_flags, want.seg_flags));
                if (got.shut_reason !== want.shut_reason)
                    report_mismatch($sformatf("shut_reason %h, want %h",
                                              got.shut_reason, want.shut_reason));
                if (got.field_value !== want.field_value)
                    report_mismatch($sformatf("field_value %h, want %h",
                                              got.field_value, want.field_value));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              got.overflow, want.overflow));
            end
        end
        m_tready <= quiet || ($urandom_range(99) >= 6);
    end

    initial begin
        int         rand_sent;
        int         sel;
        int         len;
        logic [3:0] seg_kind;
        err_count = 0;
        quiet     = 1'b0;
        clear_segment();

        // Directed table: typed records are plain to read off the spec
        add_row(8'h00, 1'b1, mk_rec(4'h0, 4'h0, 8'h00, '0, 1'b0));  // unknown type, lowest byte
        add_row(8'hFF, 1'b1, mk_rec(4'hF, 4'hF, 8'h00, '0, 1'b0));  // unknown type, highest byte
        add_row(8'h3A, 1'b1, mk_rec(TYPE_REFUSE, 4'hA, 8'h00, '0, 1'b0));
        add_row(8'h45, 1'b1, mk_rec(TYPE_KEEPALIVE, 4'h5, 8'h00, '0, 1'b0));
        add_row(8'h1C, 1'b0, '0);
        add_row(8'h05, 1'b1, mk_rec(TYPE_DATA, 4'hC, 8'h00, 63'd5, 1'b0));
        add_row(8'h2F, 1'b0, '0);                                   // ack, two-byte length
        add_row(8'h81, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h53, 1'b0, '0);                                   // shutdown
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h00, 1'b1, mk_rec(TYPE_SHUTDOWN, 4'h3, 8'hFF, '0, 1'b0));
        add_row(8'h10, 1'b0, '0);                                   // data, overlong length
        for (int i = 0; i < 9; i++)
            add_row(8'hFF, 1'b0, '0);
        add_row(8'h7F, 1'b1, mk_rec(TYPE_DATA, 4'h0, 8'h00, VALUE_ALL_ONE, 1'b1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < table_bytes.size(); i++)
            send_byte(table_bytes[i], table_typed[i], table_recs[i]);

        // Random part: mostly well-formed segments, some raw noise
        rand_sent = 0;
        while (rand_sent < 950) begin
            quiet = (rand_sent >= 350 && rand_sent < 550);
            sel   = $urandom_range(99);
            if (sel < 10) begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(255)), 1'b0, '0);
                rand_sent += len;
            end else begin
                sel = $urandom_range(99);
                if (sel < 25)
                    seg_kind = TYPE_DATA;
                else if (sel < 45)
                    seg_kind = TYPE_ACK;
                else if (sel < 65)
                    seg_kind = TYPE_SHUTDOWN;
                else
                    seg_kind = 4'($urandom_range(15));
                send_byte({seg_kind, 4'($urandom_range(15))}, 1'b0, '0);
                rand_sent++;
                if (seg_kind == TYPE_SHUTDOWN) begin
                    send_byte(8'($urandom_range(255)), 1'b0, '0);
                    rand_sent++;
                end
                if (seg_kind == TYPE_DATA || seg_kind == TYPE_ACK
                        || seg_kind == TYPE_SHUTDOWN) begin
                    sel = $urandom_range(99);
                    if (sel < 70)
                        len = $urandom_range(3, 1);
                    else if (sel < 90)
                        len = $urandom_range(9, 4);
                    else
                        len = $urandom_range(12, 10);
                    send_sdnv(len);
                    rand_sent += len;
                end
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Drain outstanding records, then keep watching for strays
        while (header_recs_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/shp_pkg.sv
hw/rtl/shp_in_reg.sv
hw/rtl/shp_core.sv
hw/rtl/shp_out_reg.sv
hw/rtl/segment_header_parser_top.sv
tb/sv/segment_header_parser_top_tb.sv
